[design/fhm_pkg.sv]
// ----------------------------------------------------------------------------
// fhm_pkg - shared definitions for the FIFO hand-off mutex
// Default sizes, result status codes, controller states and the control
// bundle that the controller drives into every queue cell.
// ----------------------------------------------------------------------------
package fhm_pkg;

   // Default sizes
   localparam int DEF_QUEUE_DEPTH    = 16;
   localparam int DEF_THREAD_ID_BITS = 8;

   // Request commands
   localparam logic CMD_LOCK   = 1'b0;
   localparam logic CMD_UNLOCK = 1'b1;

   // Result status codes
   typedef enum logic [2:0] {
      STAT_GRANTED   = 3'd0,
      STAT_QUEUED    = 3'd1,
      STAT_DUPLICATE = 3'd2,
      STAT_FULL      = 3'd3,
      STAT_RELEASED  = 3'd4,
      STAT_HANDOFF   = 3'd5
   } status_type;

   // Controller states
   typedef enum logic {
      ST_IDLE,
      ST_EVAL
   } fsm_state_type;

   // Per-cycle control broadcast to the queue cells
   typedef struct packed {
      logic capture;   // register match flags against the incoming id
      logic append;    // tail cell loads the pending id
      logic pop;       // every cell takes its upstream neighbor's entry
   } cell_ctrl_type;

endpackage

[design/fhm_cell.sv]
// ----------------------------------------------------------------------------
// fhm_cell - one slot of the wait queue
// Holds one waiting thread id. Cell 0 is the queue head. On a pop every cell
// takes the entry of the cell behind it; on an append the cell at the tail
// position loads the new id. Each cell flags a match against a request id.
// ----------------------------------------------------------------------------
module fhm_cell #(
   parameter int ID_BITS    = fhm_pkg::DEF_THREAD_ID_BITS,
   parameter int CNT_BITS   = 5,
   parameter int CELL_INDEX = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  fhm_pkg::cell_ctrl_type ctrl,
   input  logic [CNT_BITS-1:0]   fill_count,
   input  logic [ID_BITS-1:0]    match_id,
   input  logic [ID_BITS-1:0]    append_id,
   input  logic [ID_BITS-1:0]    upstream_entry,
   output logic [ID_BITS-1:0]    entry,
   output logic                  hit
);
   import fhm_pkg::*;

   logic [ID_BITS-1:0] entry_ff;
   logic [ID_BITS-1:0] entry_in;
   logic               hit_ff;
   logic               hit_in;
   logic               occupied;
   logic               at_tail;

   // Slot position relative to the fill level
   assign occupied = CNT_BITS'(CELL_INDEX) < fill_count;
   assign at_tail  = CNT_BITS'(CELL_INDEX) == fill_count;

   // Entry: shift toward the head on pop, load at the tail on append
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.pop) begin
         entry_in = upstream_entry;
      end else if (ctrl.append && at_tail) begin
         entry_in = append_id;
      end
   end

   // Match flag, sampled when a transaction is taken
   always_comb begin
      hit_in = hit_ff;
      if (ctrl.capture) begin
         hit_in = occupied && (entry_ff == match_id);
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   assign entry = entry_ff;
   assign hit   = hit_ff;

endmodule

[design/fifo_handoff_mutex_unit.sv]
// ----------------------------------------------------------------------------
// fifo_handoff_mutex_unit - hardware mutex with FIFO hand-off
// Grants a free mutex at once, queues lockers of a held mutex in a chain of
// cells, and on unlock hands ownership straight to the oldest waiter.
//
//   Channel  | Direction | Handshake          | Payload
//   ---------+-----------+--------------------+-------------------------------
//   req_     | in        | req_valid/req_stall| command, thread_id
//   rsp_     | out       | rsp_valid/rsp_stall| status, woken_thread,
//            |           |                    | current_owner, is_held, waiters
//
// Each transaction is taken in ST_IDLE, where the per-cell match flags of the
// queue are sampled, and decided in ST_EVAL, which updates owner, queue and count.
// No new request is taken until the one before it has been decided.
// Reset (synchronous) frees the mutex and empties the queue; no sweep needed.
// While a result is stalled on rsp_, requests are stalled too.
// ----------------------------------------------------------------------------
module fifo_handoff_mutex_unit #(
   parameter int QUEUE_DEPTH    = fhm_pkg::DEF_QUEUE_DEPTH,
   parameter int THREAD_ID_BITS = fhm_pkg::DEF_THREAD_ID_BITS
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_command,
   input  logic [7:0] req_thread_id,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_status,
   output logic [7:0] rsp_woken_thread,
   output logic [7:0] rsp_current_owner,
   output logic       rsp_is_held,
   output logic [4:0] rsp_waiters
);
   import fhm_pkg::*;

   localparam int IdW  = THREAD_ID_BITS;
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   fsm_state_type     state_ff;
   fsm_state_type     state_in;
   logic              req_accept;
   logic              in_eval;
   logic [IdW+7:0]    req_tid_ext;
   logic [IdW-1:0]    req_tid;

   logic              cmd_ff;
   logic [IdW-1:0]    tid_ff;
   logic              held_ff;
   logic              held_in;
   logic [IdW-1:0]    owner_ff;
   logic [IdW-1:0]    owner_in;
   logic [CntW-1:0]   count_ff;
   logic [CntW-1:0]   count_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   status_type        status_ff;
   status_type        status_in;
   logic [IdW-1:0]    woken_ff;
   logic [IdW-1:0]    woken_in;

   cell_ctrl_type     cell_ctrl;
   logic              do_append;
   logic              do_pop;
   logic [IdW-1:0]    entry [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] hit;
   logic              dup_waiter;
   logic              queue_full;
   logic              queue_empty;

   logic [IdW+7:0]    owner_ext;
   logic [IdW+7:0]    woken_ext;
   logic [CntW+4:0]   count_ext;

   // Request id folded to the configured id width
   assign req_tid_ext = {{IdW{1'b0}}, req_thread_id};
   assign req_tid     = req_tid_ext[IdW-1:0];
   assign req_accept  = req_valid && !req_stall;

   // Next state
   always_comb begin
      unique case (state_ff)
         ST_IDLE: state_in = req_accept ? ST_EVAL : ST_IDLE;
         ST_EVAL: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      unique case (state_ff)
         ST_IDLE: begin
            in_eval   = 1'b0;
            req_stall = rsp_valid_ff && rsp_stall;
         end
         ST_EVAL: begin
            in_eval   = 1'b1;
            req_stall = 1'b1;
         end
         default: begin
            in_eval   = 1'b0;
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Captured request
   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff <= req_command;
         tid_ff <= req_tid;
      end
   end

   // Queue of waiting threads
   assign cell_ctrl.capture = req_accept;
   assign cell_ctrl.append  = do_append;
   assign cell_ctrl.pop     = do_pop;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic [IdW-1:0] upstream;
      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign upstream = '0;
      end else begin : g_mid
         assign upstream = entry[i+1];
      end
      fhm_cell #(
         .ID_BITS    (IdW),
         .CNT_BITS   (CntW),
         .CELL_INDEX (i)
      ) u_cell (
         .clock          (clock),
         .reset          (reset),
         .ctrl           (cell_ctrl),
         .fill_count     (count_ff),
         .match_id       (req_tid),
         .append_id      (tid_ff),
         .upstream_entry (upstream),
         .entry          (entry[i]),
         .hit            (hit[i])
      );
   end

   assign dup_waiter  = |hit;
   assign queue_full  = count_ff == CntW'(QUEUE_DEPTH);
   assign queue_empty = count_ff == '0;

   // Decision for the transaction under evaluation
   always_comb begin
      held_in   = held_ff;
      owner_in  = owner_ff;
      count_in  = count_ff;
      status_in = status_ff;
      woken_in  = woken_ff;
      do_append = 1'b0;
      do_pop    = 1'b0;
      if (in_eval) begin
         woken_in = '0;
         if (cmd_ff == CMD_LOCK) begin
            if (!held_ff) begin
               held_in   = 1'b1;
               owner_in  = tid_ff;
               status_in = STAT_GRANTED;
            end else if (dup_waiter) begin
               status_in = STAT_DUPLICATE;
            end else if (queue_full) begin
               status_in = STAT_FULL;
            end else begin
               do_append = 1'b1;
               count_in  = count_ff + 1'b1;
               status_in = STAT_QUEUED;
            end
         end else begin
            if (queue_empty) begin
               held_in   = 1'b0;
               owner_in  = '0;
               status_in = STAT_RELEASED;
            end else begin
               // hand ownership to the queue head
               do_pop    = 1'b1;
               held_in   = 1'b1;
               owner_in  = entry[0];
               woken_in  = entry[0];
               count_in  = count_ff - 1'b1;
               status_in = STAT_HANDOFF;
            end
         end
      end
   end

   // Mutex state
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= 1'b0;
         owner_ff <= '0;
         count_ff <= '0;
      end else begin
         held_ff  <= held_in;
         owner_ff <= owner_in;
         count_ff <= count_in;
      end
   end

   // Result register; mutex state only moves when this slot is free
   assign rsp_valid_in = in_eval || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      woken_ff  <= woken_in;
   end

   // Output fields
   assign owner_ext = {8'h00, owner_ff};
   assign woken_ext = {8'h00, woken_ff};
   assign count_ext = {5'h00, count_ff};

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_woken_thread  = woken_ext[7:0];
   assign rsp_current_owner = owner_ext[7:0];
   assign rsp_is_held       = held_ff;
   assign rsp_waiters       = count_ext[4:0];

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(QUEUE_DEPTH))
      else $error("wait queue count beyond depth");

   a_free_empty: assert property (@(posedge clock) disable iff (reset)
      !held_ff |-> count_ff == '0)
      else $error("free mutex with waiters");

   a_handoff_owner: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == STAT_HANDOFF |-> held_ff && woken_ff == owner_ff)
      else $error("hand-off result does not match owner");

   a_accept_eval: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == ST_EVAL && !req_stall == 1'b0)
      else $error("accepted transaction not evaluated");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      in_eval |-> !(rsp_valid_ff && rsp_stall))
      else $error("result overwritten while stalled");

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench - self-checking bench for fifo_handoff_mutex_unit
// Drives lock and unlock transactions with random gaps, stalls the result
// side at random and once for a long stretch, and checks every result field
// against a cycle-free predictor of the mutex, its owner and its wait queue.
// ----------------------------------------------------------------------------
module testbench;
   import fhm_pkg::*;

   localparam int unsigned CYCLE_LIMIT      = 400000;
   localparam int unsigned LONG_HOLD_CYCLES = 200;
   localparam int unsigned DRAIN_CYCLES     = 10;
   localparam int unsigned MAX_IDLE         = 18;

   // One result transaction as the block reports it
   typedef struct {
      status_type status;
      logic [7:0] woken;
      logic [7:0] owner;
      logic       held;
      logic [4:0] waiters;
   } mutex_result_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_command = CMD_LOCK;
   logic [7:0] req_thread_id = 8'd0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [2:0] rsp_status;
   logic [7:0] rsp_woken_thread;
   logic [7:0] rsp_current_owner;
   logic       rsp_is_held;
   logic [4:0] rsp_waiters;

   // Predicted mutex state
   logic       mutex_held = 1'b0;
   logic [7:0] mutex_owner = 8'd0;
   logic [7:0] waiting_threads[$];

   mutex_result_type mutex_outcomes[$];

   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   int          rsp_wait_left = 0;
   bit          sender_idle_on = 1'b1;
   logic        receiver_idle_on = 1'b1;
   logic        long_hold = 1'b0;

   fifo_handoff_mutex_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_thread_id     (req_thread_id),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_woken_thread  (rsp_woken_thread),
      .rsp_current_owner (rsp_current_owner),
      .rsp_is_held       (rsp_is_held),
      .rsp_waiters       (rsp_waiters)
   );

   // Clock
   initial begin
      forever #1 clock = ~clock;
   end

   // Run-away guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout", $time);
         $display("FAIL");
         $finish;
      end
   end

   // Apply one request to the predicted mutex and return the expected result
   function automatic mutex_result_type next_mutex_outcome(logic cmd, logic [7:0] tid);
      mutex_result_type r;
      bit already_waiting;
      already_waiting = 1'b0;
      r.woken = 8'd0;
      if (cmd == CMD_LOCK) begin
         foreach (waiting_threads[i])
            if (waiting_threads[i] == tid) already_waiting = 1'b1;
         if (!mutex_held) begin
            mutex_held = 1'b1;
            mutex_owner = tid;
            r.status = STAT_GRANTED;
         end else if (already_waiting) begin
            r.status = STAT_DUPLICATE;
         end else if (waiting_threads.size() >= DEF_QUEUE_DEPTH) begin
            r.status = STAT_FULL;
         end else begin
            waiting_threads.push_back(tid);
            r.status = STAT_QUEUED;
         end
      end else begin
         // caller is not checked: any unlock acts for the owner
         if (waiting_threads.size() == 0) begin
            mutex_held = 1'b0;
            mutex_owner = 8'd0;
            r.status = STAT_RELEASED;
         end else begin
            r.woken = waiting_threads.pop_front();
            mutex_owner = r.woken;
            mutex_held = 1'b1;
            r.status = STAT_HANDOFF;
         end
      end
      r.owner = mutex_owner;
      r.held = mutex_held;
      r.waiters = 5'(waiting_threads.size());
      return r;
   endfunction

   // Predict on every accepted request transaction
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         mutex_outcomes.push_back(next_mutex_outcome(req_command, req_thread_id));
   end

   task automatic check_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endtask

   // Compare each accepted result transaction with the oldest prediction
   always @(posedge clock) begin : check_results
      mutex_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (mutex_outcomes.size() == 0) begin
            error_count++;
            $display("%0t: result with none expected, status %0d", $time, rsp_status);
         end else begin
            want = mutex_outcomes.pop_front();
            check_field("status", 8'(want.status), 8'(rsp_status));
            check_field("woken_thread", want.woken, rsp_woken_thread);
            check_field("current_owner", want.owner, rsp_current_owner);
            check_field("is_held", 8'(want.held), 8'(rsp_is_held));
            check_field("waiters", 8'(want.waiters), 8'(rsp_waiters));
         end
      end
   end

   // Result side: random stall after each transaction, plus the long hold
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall)
         rsp_wait_left = receiver_idle_on ? int'($urandom_range(0, MAX_IDLE)) : 0;
      else if (rsp_wait_left > 0)
         rsp_wait_left = rsp_wait_left - 1;
      rsp_stall <= long_hold || (rsp_wait_left > 0);
   end

   // Send one request; valid stays up afterward unless the next one idles first
   task automatic issue_request(logic cmd, logic [7:0] tid);
      int unsigned gap;
      gap = sender_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_thread_id <= tid;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Grant, owner relock, duplicate, handoff by a non-owner, unlock when free
   task automatic test_basic_ownership();
      issue_request(CMD_UNLOCK, 8'hFF);   // free mutex unlocked
      issue_request(CMD_LOCK, 8'hFF);     // granted
      issue_request(CMD_LOCK, 8'hFF);     // owner is queued behind itself
      issue_request(CMD_LOCK, 8'hFF);     // already waiting
      issue_request(CMD_LOCK, 8'h00);
      issue_request(CMD_UNLOCK, 8'h5A);   // non-owner unlock hands off
      issue_request(CMD_UNLOCK, 8'hA5);
      issue_request(CMD_UNLOCK, 8'h00);   // released
      issue_request(CMD_UNLOCK, 8'h00);
   endtask

   // Fill the wait queue, with results held back at the start, then drain it
   task automatic test_full_queue_under_backpressure();
      int i;
      sender_idle_on = 1'b0;
      fork
         begin
            long_hold <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            long_hold <= 1'b0;
         end
         begin
            issue_request(CMD_LOCK, 8'h80);
            for (i = 0; i < DEF_QUEUE_DEPTH + 1; i++)
               issue_request(CMD_LOCK, 8'(i * 15));   // last one finds the queue full
            issue_request(CMD_LOCK, 8'd30);           // duplicate beats full
         end
      join
      sender_idle_on = 1'b1;
      for (i = 0; i < DEF_QUEUE_DEPTH + 2; i++)
         issue_request(CMD_UNLOCK, 8'(i));
   endtask

   // Lock bursts followed by unlock bursts, with some random noise in between
   task automatic test_random_traffic(int unsigned item_target);
      int unsigned sent;
      int unsigned burst;
      int unsigned i;
      bit          narrow_ids;
      logic [7:0]  tid;
      sent = 0;
      while (sent < item_target) begin
         sender_idle_on = ($urandom_range(0, 3) != 0);
         receiver_idle_on <= ($urandom_range(0, 3) != 0);
         narrow_ids = ($urandom_range(0, 1) != 0);
         if ($urandom_range(0, 9) == 0) begin
            burst = $urandom_range(1, 8);
            for (i = 0; i < burst; i++)
               issue_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            sent += burst;
         end else begin
            burst = $urandom_range(1, 20);
            for (i = 0; i < burst; i++) begin
               tid = narrow_ids ? 8'($urandom_range(0, 11)) : 8'($urandom_range(0, 255));
               issue_request(CMD_LOCK, tid);
            end
            sent += burst;
            burst = $urandom_range(1, 20);
            for (i = 0; i < burst; i++)
               issue_request(CMD_UNLOCK, 8'($urandom_range(0, 255)));
            sent += burst;
         end
      end
   endtask

   // Test sequence
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_basic_ownership();
      test_full_queue_under_backpressure();
      test_random_traffic(1400);
      req_valid <= 1'b0;
      // let the predictor record the last accepted request first
      @(posedge clock);
      while (mutex_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
